/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock while out of reset
`define PRFW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define PRFW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// property checked on every clock, reset included
`define PRFW_ASSERT_RAW(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/prfw_pkg.sv */
// ----------------------------------------------------------------------------
// prfw_pkg
// shared constants and types of the page framebuffer region writer
// ----------------------------------------------------------------------------
package prfw_pkg;

  localparam int COLUMNS   = 256;
  localparam int PAGES     = 8;
  localparam int ROWS      = 8 * PAGES;
  localparam int MEM_DEPTH = PAGES * COLUMNS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam logic [7:0] CMD_PAGE    = 8'hB0;
  localparam logic [7:0] CMD_COL_HI  = 8'h10;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_PIXEL = 2'd1,
    REQ_PULL  = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIXEL,
    ST_PULL,
    ST_PULL_DATA
  } state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] x_start;
    logic [5:0] y_start;
    logic [8:0] width;
    logic [6:0] height;
    logic [7:0] pixel_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_command;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] left;
    logic [5:0] top;
    logic [8:0] width;
    logic [6:0] height;
  } region_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
  } mem_req_t;

  typedef struct packed {
    logic              pending;
    logic              data_phase;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        cmd_byte;
    logic              fin;
  } flush_info_t;

endpackage

/* rtl/prfw_ram.sv */
// ----------------------------------------------------------------------------
// prfw_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module prfw_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/prfw_pixel.sv */
// ----------------------------------------------------------------------------
// prfw_pixel
// pixel engine: one read-modify-write of the frame memory per pixel,
// with forwarding of the previous write
// ----------------------------------------------------------------------------
module prfw_pixel import prfw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  logic [7:0] pixel_byte,
  input  logic       region_load,
  input  region_t    region,
  input  logic [7:0] rd_data,
  output mem_req_t   mem_req,
  output logic       busy
);

  logic              active_r, active_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [7:0]        bits_r, bits_nxt;
  logic [8:0]        col_off_r, col_off_nxt;
  logic [6:0]        row_off_r, row_off_nxt;

  logic              s1_vld_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [2:0]        s1_bit_r;
  logic              s1_val_r;

  logic              fw_vld_r;
  logic [ADDR_W-1:0] fw_addr_r;
  logic [7:0]        fw_data_r;

  logic              run;
  logic [9:0]        col;
  logic [7:0]        row;
  logic [4:0]        page;
  logic              visible;
  logic [ADDR_W-1:0] addr;
  logic [8:0]        col_inc;
  logic [7:0]        base;
  logic [7:0]        merged;

  always_comb begin
    run     = active_r && (region.width != 9'd0) && (row_off_r < region.height);
    col     = {2'b00, region.left} + {1'b0, col_off_r};
    row     = {2'b00, region.top} + {1'b0, row_off_r};
    page    = row[7:3];
    visible = (col < 10'(COLUMNS)) && (row < 8'(ROWS));
    addr    = ADDR_W'(32'(page) * COLUMNS + 32'(col));
    col_inc = col_off_r + 9'd1;
  end

  always_comb begin
    active_nxt  = active_r;
    cnt_nxt     = cnt_r;
    bits_nxt    = bits_r;
    col_off_nxt = col_off_r;
    row_off_nxt = row_off_r;
    if (region_load) begin
      col_off_nxt = '0;
      row_off_nxt = '0;
    end
    if (go) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
      bits_nxt   = pixel_byte;
    end else if (active_r) begin
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        active_nxt = 1'b0;
      end
      if (run) begin
        if (col_inc >= region.width) begin
          col_off_nxt = '0;
          row_off_nxt = row_off_r + 7'd1;
        end else begin
          col_off_nxt = col_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      cnt_r     <= '0;
      col_off_r <= '0;
      row_off_r <= '0;
      s1_vld_r  <= 1'b0;
      fw_vld_r  <= 1'b0;
    end else begin
      active_r  <= active_nxt;
      cnt_r     <= cnt_nxt;
      col_off_r <= col_off_nxt;
      row_off_r <= row_off_nxt;
      s1_vld_r  <= run && visible;
      fw_vld_r  <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    bits_r    <= bits_nxt;
    s1_addr_r <= addr;
    s1_bit_r  <= row[2:0];
    s1_val_r  <= bits_r[cnt_r];
    fw_addr_r <= s1_addr_r;
    fw_data_r <= merged;
  end

  // read data is stale when the previous cycle wrote the same byte
  always_comb begin
    base   = (fw_vld_r && (fw_addr_r == s1_addr_r)) ? fw_data_r : rd_data;
    merged = base;
    merged[s1_bit_r] = s1_val_r;
  end

  always_comb begin
    mem_req.rd_en   = run && visible;
    mem_req.rd_addr = addr;
    mem_req.wr_en   = s1_vld_r;
    mem_req.wr_addr = s1_addr_r;
    mem_req.wr_data = merged;
  end

  assign busy = active_r;

endmodule

/* rtl/prfw_flush.sv */
// ----------------------------------------------------------------------------
// prfw_flush
// flush sequencer: page, position and pending state of the region flush
// ----------------------------------------------------------------------------
module prfw_flush import prfw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        region_load,
  input  region_t     start_region,
  input  region_t     region,
  input  logic        step,
  output flush_info_t info
);

  localparam logic [8:0] POS_PAGE   = 9'd0;
  localparam logic [8:0] POS_COL_HI = 9'd1;
  localparam logic [8:0] POS_COL_LO = 9'd2;
  localparam logic [8:0] POS_DATA   = 9'd3;

  logic [2:0] page_r, page_nxt;
  logic [8:0] pos_r, pos_nxt;
  logic       pending_r, pending_nxt;

  logic [8:0] vw;
  logic [8:0] start_vw;
  logic [4:0] last_page;
  logic [8:0] pos_inc;
  logic       row_end;
  logic       fin;
  logic [8:0] col;
  logic       start_ok;

  function automatic logic [8:0] visible_width(region_t r);
    logic [8:0] room;
    logic [8:0] res;
    room = 9'(COLUMNS) - {1'b0, r.left};
    if ({1'b0, r.left} >= 9'(COLUMNS)) begin
      res = '0;
    end else begin
      res = (r.width < room) ? r.width : room;
    end
    return res;
  endfunction

  function automatic logic [4:0] final_page(region_t r);
    logic [7:0] bottom;
    logic [4:0] p;
    bottom = {2'b00, r.top} + {1'b0, r.height} - 8'd1;
    p      = bottom[7:3];
    return (p < 5'(PAGES - 1)) ? p : 5'(PAGES - 1);
  endfunction

  always_comb begin
    vw        = visible_width(region);
    start_vw  = visible_width(start_region);
    last_page = final_page(region);
    pos_inc   = pos_r + 9'd1;
    row_end   = {1'b0, pos_inc} >= ({1'b0, vw} + 10'd3);
    fin       = row_end && ({2'b00, page_r} >= last_page);
    col       = {1'b0, region.left} + (pos_r - POS_DATA);
    start_ok  = (start_region.width != 9'd0) && (start_region.height != 7'd0) &&
                (start_vw != 9'd0) && (4'(start_region.top[5:3]) < 4'(PAGES));
  end

  always_comb begin
    page_nxt    = page_r;
    pos_nxt     = pos_r;
    pending_nxt = pending_r;
    if (region_load) begin
      page_nxt    = start_region.top[5:3];
      pos_nxt     = '0;
      pending_nxt = start_ok;
    end else if (step) begin
      if (row_end) begin
        pos_nxt = '0;
        if (fin) begin
          pending_nxt = 1'b0;
        end else begin
          page_nxt = page_r + 3'd1;
        end
      end else begin
        pos_nxt = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r    <= '0;
      pos_r     <= '0;
      pending_r <= 1'b0;
    end else begin
      page_r    <= page_nxt;
      pos_r     <= pos_nxt;
      pending_r <= pending_nxt;
    end
  end

  always_comb begin
    info.pending    = pending_r;
    info.data_phase = pos_r >= POS_DATA;
    info.rd_addr    = ADDR_W'(32'(page_r) * COLUMNS + 32'(col));
    info.fin        = fin;
    case (pos_r)
      POS_PAGE:   info.cmd_byte = CMD_PAGE + {5'b00000, page_r};
      POS_COL_HI: info.cmd_byte = CMD_COL_HI + ((region.left >> 4) & NIBBLE_MASK);
      POS_COL_LO: info.cmd_byte = region.left & NIBBLE_MASK;
      default:    info.cmd_byte = '0;
    endcase
  end

endmodule

/* rtl/page_framebuffer_region_writer.sv */
// ----------------------------------------------------------------------------
// page_framebuffer_region_writer
// page-organized 1-bit framebuffer with region writes and flush byte stream
// ----------------------------------------------------------------------------
// start beat: taken in idle. pixel byte: eight read-modify-write slots on
// the single frame memory plus entry and exit of the pixel engine. pull
// beat: waits for a free output slot; a command byte is registered from
// ST_PULL, a data byte read there and registered from ST_PULL_DATA; the
// next beat is taken when the result is valid. after reset the frame memory is
// cleared, one entry a cycle, in_ready low; all control state resets to zero.
module page_framebuffer_region_writer import prfw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat
);

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  region_t           region_r;
  region_t           start_region;
  logic              out_valid_r;
  out_beat_t         out_beat_r;

  logic              accept;
  logic              start_go;
  logic              pixel_go;
  logic              clr_last;
  logic              slot_free;
  logic              clr_we;
  logic              flush_rd;
  logic              load_cmd;
  logic              load_data;
  logic              flush_step;

  mem_req_t          pix_req;
  logic              pix_busy;
  flush_info_t       flush_info;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  assign accept    = in_valid && in_ready;
  assign start_go  = accept && (in_beat.req_type == REQ_START);
  assign pixel_go  = accept && (in_beat.req_type == REQ_PIXEL);
  assign clr_last  = clr_addr_r == ADDR_W'(MEM_DEPTH - 1);
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    start_region.left   = in_beat.x_start;
    start_region.top    = in_beat.y_start;
    start_region.width  = in_beat.width;
    start_region.height = in_beat.height;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (in_beat.req_type)
            REQ_PIXEL: state_nxt = ST_PIXEL;
            REQ_PULL:  state_nxt = ST_PULL;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PIXEL: begin
        if (!pix_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PULL: begin
        if (slot_free) begin
          if (flush_info.pending && flush_info.data_phase) begin
            state_nxt = ST_PULL_DATA;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_PULL_DATA: state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    clr_we    = 1'b0;
    flush_rd  = 1'b0;
    load_cmd  = 1'b0;
    load_data = 1'b0;
    case (state_r)
      ST_CLEAR: clr_we = 1'b1;
      ST_IDLE:  in_ready = 1'b1;
      ST_PULL: begin
        flush_rd = slot_free && flush_info.pending && flush_info.data_phase;
        load_cmd = slot_free && flush_info.pending && !flush_info.data_phase;
      end
      ST_PULL_DATA: load_data = 1'b1;
      default: in_ready = 1'b0;
    endcase
  end

  assign flush_step   = load_cmd || load_data;
  assign clr_addr_nxt = clr_addr_r + ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      region_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_we) begin
        clr_addr_r <= clr_addr_nxt;
      end
      if (start_go) begin
        region_r <= start_region;
      end
      if (flush_step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_cmd) begin
      out_beat_r.out_byte   <= flush_info.cmd_byte;
      out_beat_r.is_command <= 1'b1;
      out_beat_r.last       <= flush_info.fin;
    end else if (load_data) begin
      out_beat_r.out_byte   <= ram_rdata;
      out_beat_r.is_command <= 1'b0;
      out_beat_r.last       <= flush_info.fin;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  always_comb begin
    if (clr_we) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = pix_req.wr_en;
      ram_waddr = pix_req.wr_addr;
      ram_wdata = pix_req.wr_data;
    end
    ram_re    = flush_rd || pix_req.rd_en;
    ram_raddr = flush_rd ? flush_info.rd_addr : pix_req.rd_addr;
  end

  prfw_ram #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  prfw_pixel u_pixel (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (pixel_go),
    .pixel_byte  (in_beat.pixel_byte),
    .region_load (start_go),
    .region      (region_r),
    .rd_data     (ram_rdata),
    .mem_req     (pix_req),
    .busy        (pix_busy)
  );

  prfw_flush u_flush (
    .clk          (clk),
    .rst_n        (rst_n),
    .region_load  (start_go),
    .start_region (start_region),
    .region       (region_r),
    .step         (flush_step),
    .info         (flush_info)
  );

endmodule

/* rtl/prfw_checker.sv */
// ----------------------------------------------------------------------------
// prfw_checker
// port-level checks of the page framebuffer region writer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prfw_checker import prfw_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_beat_t  in_beat,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_beat
);

  `PRFW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_beat), "stalled out beat changed")
  `PRFW_ASSERT_ALWAYS(a_last_is_data, !(out_valid && out_beat.last && out_beat.is_command), "last beat flagged as command")
  `PRFW_ASSERT_NEXT(a_no_spurious_out, in_valid && in_ready && (in_beat.req_type != REQ_PULL), !$rose(out_valid), "out beat without a pull")
  `PRFW_ASSERT_RAW(a_clear_after_reset, !$past(rst_n) |-> !in_ready, "in_ready high during memory clear")

endmodule

bind page_framebuffer_region_writer prfw_checker u_prfw_checker (.*);

/* tb/page_framebuffer_region_writer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_region_writer_tb
// Drives region starts, packed pixel bytes and pull requests into the region
// writer and keeps a shadow copy of the page framebuffer and the flush
// state. Every pull that should produce a byte queues the predicted command
// or data beat, and each beat the block returns is compared field by field.
// ----------------------------------------------------------------------------
module page_framebuffer_region_writer_tb import prfw_pkg::*; ();

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int         USEFUL_GOAL = 800;
  localparam int         HOLD_CYCLES = 300;
  localparam int         CYCLE_LIMIT = 600000;

  class frame_shadow;
    logic [7:0]  fb_mem [MEM_DEPTH];
    int unsigned left, top, wid, hgt;
    int unsigned col_off, row_off, page, pos;
    bit          flushing;
    out_beat_t   flush_q[$];
    int          mismatches;

    function new();
      foreach (fb_mem[i]) fb_mem[i] = 8'h00;
      left = 0; top = 0; wid = 0; hgt = 0;
      col_off = 0; row_off = 0; page = 0; pos = 0;
      flushing = 0;
      mismatches = 0;
    endfunction

    function int unsigned visible_cols();
      int unsigned room;
      if (left >= COLUMNS) return 0;
      room = COLUMNS - left;
      return (wid < room) ? wid : room;
    endfunction

    function int unsigned last_page();
      int unsigned p;
      p = (top + hgt - 1) / 8;
      return (p < PAGES - 1) ? p : PAGES - 1;
    endfunction

    // pulls still needed to finish the current flush
    function int unsigned bytes_left();
      int unsigned span;
      if (!flushing) return 0;
      span = visible_cols() + 3;
      return (span - pos) + (last_page() - page) * span;
    endfunction

    // returns 1 when the beat changes state or yields a byte
    function bit take_request(in_beat_t b);
      int unsigned col, row, idx, vc;
      out_beat_t   exp_beat;
      bit          used;
      used = 0;
      case (b.req_type)
        REQ_START: begin
          left = b.x_start; top = b.y_start; wid = b.width; hgt = b.height;
          col_off = 0; row_off = 0; pos = 0;
          page = (top / 8) % 8;
          flushing = (wid != 0) && (hgt != 0) && (visible_cols() != 0) && (top / 8 < PAGES);
          used = 1;
        end
        REQ_PIXEL: begin
          for (int i = 0; i < 8; i++) begin
            if (wid == 0 || row_off >= hgt) break;
            col = left + col_off;
            row = top + row_off;
            if (col < COLUMNS && row < ROWS) begin
              idx = ((row / 8) * COLUMNS + col) % MEM_DEPTH;
              fb_mem[idx][row % 8] = b.pixel_byte[i];
            end
            col_off++;
            if (col_off >= wid) begin
              col_off = 0;
              row_off++;
            end
            used = 1;
          end
        end
        REQ_PULL: begin
          if (flushing) begin
            vc = visible_cols();
            if (pos == 0) begin
              exp_beat.out_byte   = CMD_PAGE + 8'(page);
              exp_beat.is_command = 1'b1;
            end else if (pos == 1) begin
              exp_beat.out_byte   = CMD_COL_HI + ((8'(left) >> 4) & NIBBLE_MASK);
              exp_beat.is_command = 1'b1;
            end else if (pos == 2) begin
              exp_beat.out_byte   = 8'(left) & NIBBLE_MASK;
              exp_beat.is_command = 1'b1;
            end else begin
              idx = (page * COLUMNS + left + pos - 3) % MEM_DEPTH;
              exp_beat.out_byte   = fb_mem[idx];
              exp_beat.is_command = 1'b0;
            end
            exp_beat.last = 1'b0;
            pos++;
            if (pos >= vc + 3) begin
              pos = 0;
              if (page >= last_page()) begin
                flushing = 0;
                exp_beat.last = 1'b1;
              end else begin
                page = (page + 1) % 8;
              end
            end
            flush_q.push_back(exp_beat);
            used = 1;
          end
        end
        default: used = 0;
      endcase
      return used;
    endfunction

    function void check_flush_byte(out_beat_t got);
      out_beat_t want;
      if (flush_q.size() == 0) begin
        $error("unexpected beat: out_byte %02h is_command %0b last %0b",
               got.out_byte, got.is_command, got.last);
        mismatches++;
        return;
      end
      want = flush_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.is_command !== want.is_command) begin
        $error("is_command: expected %0b, got %0b", want.is_command, got.is_command);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_beat;

  frame_shadow sb;
  int          idle_pct;
  int          stall_pct;
  bit          hold_request;
  int          useful_items;
  int          cycle_count;

  page_framebuffer_region_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_flush_byte(out_beat);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
        hold_request = 0;
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic in_beat_t random_beat(input logic [1:0] req);
    in_beat_t b;
    b            = '0;
    b.req_type   = req;
    b.x_start    = 8'($urandom);
    b.y_start    = 6'($urandom);
    b.width      = 9'($urandom);
    b.height     = 7'($urandom);
    b.pixel_byte = 8'($urandom);
    return b;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_beat(input in_beat_t b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (!in_ready);
    if (sb.take_request(b)) useful_items++;
    @(negedge clk);
  endtask

  task automatic send_start(input int unsigned x, y, w, h);
    in_beat_t b;
    b         = random_beat(REQ_START);
    b.x_start = 8'(x);
    b.y_start = 6'(y);
    b.width   = 9'(w);
    b.height  = 7'(h);
    send_beat(b);
  endtask

  task automatic send_pixels(input logic [7:0] bits);
    in_beat_t b;
    b            = random_beat(REQ_PIXEL);
    b.pixel_byte = bits;
    send_beat(b);
  endtask

  task automatic send_pull();
    send_beat(random_beat(REQ_PULL));
  endtask

  // start, the bitmap for it, then the flush pulls
  task automatic region_sequence(input bit squeeze);
    int unsigned x, y, w, h, nbytes, extra, budget;
    int          r;
    bit          abandon;
    r = $urandom_range(0, 99);
    x = $urandom_range(0, 255);
    y = $urandom_range(0, 63);
    if (squeeze) begin
      x = 16; y = 4; w = 40; h = 16;
    end else if (r < 4) begin
      w = $urandom_range(1, 511); h = $urandom_range(1, 6);
    end else if (r < 8) begin
      w = $urandom_range(1, 6); h = $urandom_range(1, 127);
    end else if (r < 10) begin
      w = (r == 8) ? 0 : $urandom_range(1, 8);
      h = (r == 9) ? 0 : $urandom_range(1, 8);
    end else begin
      w = $urandom_range(1, 24); h = $urandom_range(1, 20);
    end
    send_start(x, y, w, h);
    nbytes = (w * h + 7) / 8;
    extra  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    for (int k = 0; k < nbytes + extra; k++) begin
      send_pixels(8'($urandom));
      if (!squeeze && $urandom_range(0, 9) == 0) send_pull();
    end
    if (squeeze) hold_request = 1;
    abandon = !squeeze && ($urandom_range(0, 4) == 0);
    budget  = abandon ? $urandom_range(0, 8) : 32'hffff_ffff;
    while (sb.bytes_left() > 0 && budget > 0) begin
      send_pull();
      budget--;
    end
    if (!abandon && $urandom_range(0, 3) == 0) send_pull();
  endtask

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_beat      = '0;
    out_ready    = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_request = 0;
    useful_items = 0;
    cycle_count  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // pull with nothing pending, unknown request
    send_pull();
    send_beat(random_beat(REQ_UNKNOWN) | in_beat_t'({$bits(in_beat_t){1'b1}}));
    // exact bitmap plus one extra byte, then full flush and an idle pull
    send_start(0, 0, 3, 8);
    send_pixels(8'hff);
    send_pixels(8'h00);
    send_pixels(8'ha5);
    send_pixels(8'h3c);
    repeat (7) send_pull();
    // all-ones region: off-panel pixels, then a start during the flush
    send_start(255, 63, 511, 127);
    send_pixels(8'haa);
    send_pixels(8'h55);
    send_pull();
    send_pull();
    // zero width and zero height
    send_start(10, 10, 0, 5);
    send_pixels(8'hff);
    send_pull();
    send_start(10, 10, 4, 0);
    send_pixels(8'hff);
    send_pull();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin
          idle_pct  = 0;
          stall_pct = 54;
          region_sequence(1);
        end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      while (useful_items < (ph + 1) * USEFUL_GOAL / 4) begin
        if ($urandom_range(0, 99) < 15)
          send_beat(random_beat(2'($urandom_range(0, 3))));
        else
          region_sequence(0);
      end
    end
    in_valid <= 1'b0;

    while (sb.flush_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.flush_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
